>>> sv/aip_pkg.sv
`default_nettype none
package aip_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int OFFSET_BITS_DEF = 16;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [APB_AW-3:0] REG_RADIX       = 1'b0;
    localparam logic [APB_AW-3:0] REG_SIGNED_MODE = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic               SIGNED_RESET = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 6'd36;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               signed_mode;
    } t_cfg;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd36;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
                d = c - CH_LO_A + 8'd10;
            end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
                d = c - CH_UP_A + 8'd10;
            end
            digit_of = d[DIGIT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/aip_cfg.sv
`default_nettype none
module aip_cfg
    import aip_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [RADIX_W-1:0] r_radix;
    logic               r_signed_mode;
    logic               wr_en;
    logic [APB_AW-3:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= RADIX_RESET;
            r_signed_mode <= SIGNED_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RADIX:       r_radix       <= pwdata[RADIX_W-1:0];
                REG_SIGNED_MODE: r_signed_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RADIX:       prdata = {{(APB_DW-RADIX_W){1'b0}}, r_radix};
            REG_SIGNED_MODE: prdata = {{(APB_DW-1){1'b0}}, r_signed_mode};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.radix       = r_radix;
    assign o_cfg.signed_mode = r_signed_mode;

endmodule
`default_nettype wire

>>> sv/aip_parse.sv
`default_nettype none
module aip_parse
    import aip_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_in_valid,
    input  wire logic [7:0]             i_ch,
    input  wire logic                   i_start_req,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [VALUE_BITS-1:0]       o_value,
    output logic [OFFSET_BITS-1:0]      o_end_offset,
    output logic                        o_offset_saturated
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_FIRST  = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    logic                   r_in_vld;
    logic [7:0]             r_ch;
    logic                   r_start;

    logic [2:0]             r_phase,  n_phase;
    logic [RADIX_W-1:0]     r_radix,  n_radix;
    logic                   r_neg,    n_neg;
    logic [VALUE_BITS-1:0]  r_acc,    n_acc;
    logic [OFFSET_BITS-1:0] r_cnt,    n_cnt;
    logic                   r_over,   n_over;

    logic                   r_out_vld;
    logic [VALUE_BITS-1:0]  r_value;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_sat;

    logic                   emit;
    logic                   advance;
    logic                   in_take;
    logic [DIGIT_W-1:0]     dig;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign dig        = digit_of(r_ch);

    always_comb begin
        logic done;
        logic bump;
        done    = 1'b0;
        bump    = 1'b0;
        emit    = 1'b0;
        n_phase = r_phase;
        n_radix = r_radix;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_over  = r_over;
        if (r_start) begin
            n_phase = PH_LEAD;
            n_radix = i_cfg.radix;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_cnt   = '0;
            n_over  = 1'b0;
        end
        if (n_phase == PH_IDLE) begin
            done = 1'b1;
        end
        if (!done && n_phase == PH_LEAD) begin
            if (r_ch == CH_SPACE || r_ch == CH_TAB || r_ch == CH_LF) begin
                bump = 1'b1;
                done = 1'b1;
            end else if (r_ch == CH_PLUS) begin
                bump    = 1'b1;
                n_phase = PH_FIRST;
                done    = 1'b1;
            end else if (r_ch == CH_MINUS && i_cfg.signed_mode) begin
                n_neg   = 1'b1;
                bump    = 1'b1;
                n_phase = PH_FIRST;
                done    = 1'b1;
            end else begin
                n_phase = PH_FIRST;
            end
        end
        if (!done && n_phase == PH_FIRST) begin
            if (r_ch == CH_ZERO && (n_radix == RADIX_AUTO || n_radix == RADIX_HEX)) begin
                bump    = 1'b1;
                n_phase = PH_ZERO;
                done    = 1'b1;
            end else begin
                if (n_radix == RADIX_AUTO) begin
                    n_radix = RADIX_DEC;
                end
                n_phase = PH_DIGITS;
            end
        end
        if (!done && n_phase == PH_ZERO) begin
            if (r_ch == CH_LO_X || r_ch == CH_UP_X) begin
                n_radix = RADIX_HEX;
                bump    = 1'b1;
                n_phase = PH_DIGITS;
                done    = 1'b1;
            end else begin
                if (n_radix == RADIX_AUTO) begin
                    n_radix = RADIX_OCT;
                end
                n_phase = PH_DIGITS;
            end
        end
        if (!done) begin
            if (dig < n_radix) begin
                n_acc = n_acc * VALUE_BITS'(n_radix) + VALUE_BITS'(dig);
                bump  = 1'b1;
            end else begin
                emit    = 1'b1;
                n_phase = PH_IDLE;
            end
        end
        if (bump) begin
            if (&n_cnt) begin
                n_over = 1'b1;
            end else begin
                n_cnt = n_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_IDLE;
            r_radix   <= '0;
            r_neg     <= 1'b0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_over    <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_radix <= n_radix;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_over  <= n_over;
            end
            if (advance && emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch    <= i_ch;
            r_start <= i_start_req;
        end
        if (advance && emit) begin
            r_value  <= n_neg ? (~n_acc + 1'b1) : n_acc;
            r_offset <= n_cnt;
            r_sat    <= n_over;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_value            = r_value;
    assign o_end_offset       = r_offset;
    assign o_offset_saturated = r_sat;

endmodule
`default_nettype wire

>>> sv/ascii_integer_parser_unit.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall     i_ch, i_start_req
// out       output     o_out_valid / i_out_stall   o_value, o_end_offset, o_offset_saturated
// cfg       input      APB (psel, penable, pwrite) paddr, pwdata, prdata
//
// One word per cycle while the output does not stall: input register, one parse step
// with a single multiply-add, result register; a terminating word passes all three in turn.
// Reset is synchronous on i_rst_n and returns the parser to idle, radix 10, signed.
// A stall on the output holds the result; the input register then stalls only
// when a word waits that cannot advance.
`default_nettype none
module ascii_integer_parser_unit
    import aip_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic      [APB_DW-1:0]      prdata,
    output logic                        pready,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_ch,
    input  wire logic                   i_start_req,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [VALUE_BITS-1:0]       o_value,
    output logic [OFFSET_BITS-1:0]      o_end_offset,
    output logic                        o_offset_saturated
);

    t_cfg cfg;

    aip_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aip_parse #(
        .VALUE_BITS  (VALUE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_in_valid         (i_in_valid),
        .i_ch               (i_ch),
        .i_start_req        (i_start_req),
        .o_in_stall         (o_in_stall),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_value            (o_value),
        .o_end_offset       (o_end_offset),
        .o_offset_saturated (o_offset_saturated)
    );

endmodule
`default_nettype wire
